// ===== src/audio_echo_delay_line_core_macros.svh =====
// Assertion macros for the checker of the echo delay line.
`ifndef AUDIO_ECHO_DELAY_LINE_CORE_MACROS_SVH
`define AUDIO_ECHO_DELAY_LINE_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AED_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AED_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`define AED_ASSERT_DLY2(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

// ===== src/aed_pkg.sv =====
// Types and constants of the audio echo delay line.
package aed_pkg;

	localparam int SAMPLE_W = 16;
	localparam int DELAY_W = 10;
	localparam int GAIN_W = 7;
	localparam int CFG_W = 10;
	localparam int CFG_IDX_W = 2;

	// 44.1 kHz stereo gives 88 interleaved samples per millisecond.
	localparam int SAMPLES_PER_MS = 88;
	// Width of delay_ms * 88 before it is wrapped to the ring.
	localparam int DIST_W = 17;

	// Gain coefficient: ceil(gain * 2^22 / 100) = gain * 41943 + ceil(gain / 25).
	localparam int COEF_W = 23;
	localparam int COEF_SH = 22;
	localparam int GAIN_RECIP = 41943;
	localparam int GAIN_FRAC_STEP = 25;

	localparam int SETTLE_CYCLES = 3;

	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
	localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = -16'sh8000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DELAY_MS  = 2'd0,
		CFG_ECHO_GAIN = 2'd1,
		CFG_STORE_WET = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_in;
		logic                       last_in_block;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_out;
		logic                       last_out;
	} out_item_t;

endpackage

// ===== src/aed_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module aed_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/audio_echo_delay_line_core.sv =====
// Echo delay line core: mixes each interleaved stereo sample with a gain-scaled copy of the
// sample stored delay_ms * 88 places earlier in a ring of RING_SAMPLES entries, saturates the
// sum to 16 bits and writes either the mix or the dry sample back into the ring. One item is
// accepted per clock unless backpressure or a register write holds the input; its result moves
// from the input register stage to the output register, and the next item is taken in the same
// cycle that a waiting result is handed on. The rate is set by the delay store, which gives
// one read and one write per cycle, and by the single stage that turns a read sample into the
// value written back. After any register write the input pauses while the wrapped delay
// distance is recomputed. The store needs no clearing pass: since the write pointer starts at
// zero and moves in order, an entry is known to be unwritten when the ring has not yet wrapped
// and the entry lies at or beyond the pointer, and such an entry reads as zero.
module audio_echo_delay_line_core #(
	parameter int RING_SAMPLES = 65536
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  aed_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output aed_pkg::out_item_t                  out_data,
	input  logic                                cfg_we,
	input  logic [aed_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [aed_pkg::CFG_W-1:0]           cfg_wdata
);

	localparam int PTR_W = $clog2(RING_SAMPLES);
	localparam int WK_W = ((PTR_W > aed_pkg::DIST_W) ? PTR_W : aed_pkg::DIST_W) + 1;
	localparam int RECIP_SH = 34;
	localparam int RECIP_W = RECIP_SH + 1 - PTR_W;
	localparam int RQ_W = RECIP_SH + aed_pkg::DIST_W;
	localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / RING_SAMPLES;
	localparam logic [WK_W-1:0] RING_WK = WK_W'(RING_SAMPLES);
	localparam logic [PTR_W:0] RING_PX = (PTR_W + 1)'(RING_SAMPLES);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_SAMPLES - 1);
	localparam logic [RECIP_W-1:0] RECIP_C = RECIP_W'(RECIP);
	localparam int SETTLE_W = 2;

	// Configuration registers
	logic [aed_pkg::DELAY_W-1:0] delay_ms_q;
	logic [aed_pkg::GAIN_W-1:0]  echo_gain_q;
	logic                        store_wet_q;
	logic [SETTLE_W-1:0]         settle_q;

	// Delay distance and gain coefficient derived from the registers
	logic [aed_pkg::DIST_W-1:0]  dist_q;
	logic [aed_pkg::DIST_W-1:0]  quot_q;
	logic [PTR_W-1:0]            gap_q;
	logic [aed_pkg::COEF_W-1:0]  coef_q;
	logic [aed_pkg::COEF_W-1:0]  coef_d;
	logic [RQ_W-1:0]             rq_full;
	logic [WK_W-1:0]             qr_wk;
	logic [WK_W-1:0]             rem_raw;
	logic [WK_W-1:0]             rem_fix;

	// Ring pointer and fill tracking
	logic [PTR_W-1:0] wp_q;
	logic             wrapped_q;
	logic [PTR_W-1:0] rd_addr;
	logic [PTR_W:0]   rd_wrap;
	logic             rd_hit;

	// Input register stage
	logic                                s1_valid_q;
	logic signed [aed_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                last_s1;
	logic [PTR_W-1:0]                    wp_s1;
	logic                                hit_s1;
	logic                                fwd_s1;
	logic [aed_pkg::SAMPLE_W-1:0]        fwd_data_s1;

	// Result register
	logic               out_valid_q;
	aed_pkg::out_item_t out_data_q;

	logic                                in_go;
	logic                                s1_go;
	logic [aed_pkg::SAMPLE_W-1:0]        ram_rdata;
	logic [aed_pkg::SAMPLE_W-1:0]        delayed;
	logic                                delayed_neg;
	logic [aed_pkg::SAMPLE_W:0]          delayed_mag;
	logic [aed_pkg::SAMPLE_W+aed_pkg::COEF_W:0] scaled_full;
	logic [aed_pkg::SAMPLE_W:0]          scaled_mag;
	logic signed [aed_pkg::SAMPLE_W+1:0] scaled_s;
	logic signed [aed_pkg::SAMPLE_W+2:0] sum_s;
	logic signed [aed_pkg::SAMPLE_W-1:0] mix;
	logic [aed_pkg::SAMPLE_W-1:0]        store_data;

	assign s1_go = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = (settle_q == '0) && (!s1_valid_q || s1_go);
	assign in_go = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_ms_q <= '0;
			echo_gain_q <= '0;
			store_wet_q <= 1'b1;
			settle_q <= '0;
		end else if (cfg_we) begin
			settle_q <= SETTLE_W'(aed_pkg::SETTLE_CYCLES);
			unique case (cfg_index)
				aed_pkg::CFG_DELAY_MS: delay_ms_q <= cfg_wdata[aed_pkg::DELAY_W-1:0];
				aed_pkg::CFG_ECHO_GAIN: echo_gain_q <= cfg_wdata[aed_pkg::GAIN_W-1:0];
				aed_pkg::CFG_STORE_WET: store_wet_q <= cfg_wdata[0];
				default: ;
			endcase
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SETTLE_W'(1);
		end
	end

	// Wrap delay_ms * 88 to the ring with a reciprocal estimate that is at most one low,
	// followed by a single corrective subtract.
	assign rq_full = RQ_W'(dist_q) * RQ_W'(RECIP_C);
	assign qr_wk = WK_W'(quot_q) * RING_WK;
	assign rem_raw = WK_W'(dist_q) - qr_wk;
	assign rem_fix = (rem_raw >= RING_WK) ? (rem_raw - RING_WK) : rem_raw;

	always_comb begin
		coef_d = aed_pkg::COEF_W'(echo_gain_q) * aed_pkg::COEF_W'(aed_pkg::GAIN_RECIP);
		coef_d = coef_d + aed_pkg::COEF_W'(echo_gain_q > '0)
			+ aed_pkg::COEF_W'(echo_gain_q > aed_pkg::GAIN_W'(aed_pkg::GAIN_FRAC_STEP))
			+ aed_pkg::COEF_W'(echo_gain_q > aed_pkg::GAIN_W'(2 * aed_pkg::GAIN_FRAC_STEP))
			+ aed_pkg::COEF_W'(echo_gain_q > aed_pkg::GAIN_W'(3 * aed_pkg::GAIN_FRAC_STEP))
			+ aed_pkg::COEF_W'(echo_gain_q > aed_pkg::GAIN_W'(4 * aed_pkg::GAIN_FRAC_STEP))
			+ aed_pkg::COEF_W'(echo_gain_q > aed_pkg::GAIN_W'(5 * aed_pkg::GAIN_FRAC_STEP));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			quot_q <= '0;
			gap_q <= '0;
			coef_q <= '0;
		end else begin
			dist_q <= aed_pkg::DIST_W'(delay_ms_q) * aed_pkg::DIST_W'(aed_pkg::SAMPLES_PER_MS);
			quot_q <= rq_full[RECIP_SH +: aed_pkg::DIST_W];
			gap_q <= rem_fix[PTR_W-1:0];
			coef_q <= coef_d;
		end
	end

	// Read position behind the write pointer, wrapped into the ring.
	always_comb begin
		rd_wrap = {1'b0, wp_q} + RING_PX - {1'b0, gap_q};
		if (wp_q >= gap_q) begin
			rd_addr = wp_q - gap_q;
		end else begin
			rd_addr = rd_wrap[PTR_W-1:0];
		end
		rd_hit = wrapped_q || (rd_addr < wp_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			wrapped_q <= 1'b0;
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_go) begin
				wp_q <= (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
				if (wp_q == PTR_LAST) begin
					wrapped_q <= 1'b1;
				end
			end
			if (in_go) begin
				s1_valid_q <= 1'b1;
			end else if (s1_go) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_go) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The store write of the item leaving the stage lands on the same edge as the next read,
	// so a read of that entry takes the written value directly.
	always_ff @(posedge clk) begin
		if (in_go) begin
			sample_s1 <= in_data.sample_in;
			last_s1 <= in_data.last_in_block;
			wp_s1 <= wp_q;
			hit_s1 <= rd_hit;
			fwd_s1 <= s1_go && (wp_s1 == rd_addr);
			fwd_data_s1 <= store_data;
		end
		if (s1_go) begin
			out_data_q.sample_out <= mix;
			out_data_q.last_out <= last_s1;
		end
	end

	aed_ram #(
		.WIDTH(aed_pkg::SAMPLE_W),
		.DEPTH(RING_SAMPLES)
	) u_delay_store (
		.clk  (clk),
		.we   (s1_go),
		.waddr(wp_s1),
		.wdata(store_data),
		.re   (in_go),
		.raddr(rd_addr),
		.rdata(ram_rdata)
	);

	// Scale by gain / 100 on the magnitude so that the quotient truncates toward zero.
	always_comb begin
		if (fwd_s1) begin
			delayed = fwd_data_s1;
		end else if (hit_s1) begin
			delayed = ram_rdata;
		end else begin
			delayed = '0;
		end
		delayed_neg = delayed[aed_pkg::SAMPLE_W-1];
		if (delayed_neg) begin
			delayed_mag = {1'b0, ~delayed} + (aed_pkg::SAMPLE_W + 1)'(1);
		end else begin
			delayed_mag = {1'b0, delayed};
		end
		scaled_full = (aed_pkg::SAMPLE_W + aed_pkg::COEF_W + 1)'(delayed_mag)
			* (aed_pkg::SAMPLE_W + aed_pkg::COEF_W + 1)'(coef_q);
		scaled_mag = scaled_full[aed_pkg::COEF_SH +: (aed_pkg::SAMPLE_W + 1)];
		if (delayed_neg) begin
			scaled_s = -$signed({1'b0, scaled_mag});
		end else begin
			scaled_s = $signed({1'b0, scaled_mag});
		end
		sum_s = (aed_pkg::SAMPLE_W + 3)'(scaled_s) + (aed_pkg::SAMPLE_W + 3)'(sample_s1);
		if (sum_s > (aed_pkg::SAMPLE_W + 3)'(aed_pkg::SAMPLE_MAX)) begin
			mix = aed_pkg::SAMPLE_MAX;
		end else if (sum_s < (aed_pkg::SAMPLE_W + 3)'(aed_pkg::SAMPLE_MIN)) begin
			mix = aed_pkg::SAMPLE_MIN;
		end else begin
			mix = sum_s[aed_pkg::SAMPLE_W-1:0];
		end
		store_data = store_wet_q ? mix : sample_s1;
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

// ===== src/aed_checker.sv =====
// Port-level checker for the echo delay line core, bound to the core module.
`include "audio_echo_delay_line_core_macros.svh"

module aed_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input aed_pkg::out_item_t out_data,
	input logic               cfg_we
);

	// A stalled result holds its value.
	`AED_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed or dropped")

	// An accepted item is expected to reach the output register via the input register stage.
	`AED_ASSERT_DLY2(a_item_reaches_out, clk, arst_n, in_valid && in_ready, out_valid, "accepted item did not reach the output")

	// A register write pauses the input while the delay distance settles.
	`AED_ASSERT_NEXT(a_cfg_pause, clk, arst_n, cfg_we, !in_ready, "input taken right after a register write")

	// Outside the settling window, the input only stalls on output backpressure.
	`AED_ASSERT_NOW(a_stall_cause, clk, arst_n, !in_ready && !$past(cfg_we) && !$past(cfg_we, 2) && !$past(cfg_we, 3), out_valid && !out_ready, "input stalled without backpressure")

endmodule

bind audio_echo_delay_line_core aed_checker u_aed_checker (.*);
